// ----- design/spiram_pkg.sv -----
`timescale 1ns / 1ps

package spiram_pkg;

  localparam int BITS_PER_WORD = 8;
  localparam int BIT_IDX_W     = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [7:0] READ_FLAG    = 8'h80;
  localparam logic [6:0] ADDR_MASK    = 7'h7F;
  localparam logic [7:0] BYTE_ALL_ONE = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] PHASE_RESET  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOCK_MODE  = 1'b0,
    CFG_PHASE_TICKS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_BURST = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR_LO = 3'd1,
    PH_ADDR_HI = 3'd2,
    PH_DATA_LO = 3'd3,
    PH_DATA_HI = 3'd4
  } phase_t;

  typedef struct packed {
    logic       clock_mode;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] action;
    logic [6:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] burst_length;
    logic       miso;
  } in_item_t;

  typedef struct packed {
    logic       cs_n;
    logic       sck;
    logic       mosi;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       read_invalid;
    logic       write_done;
    logic       rejected;
  } out_item_t;

endpackage

// ----- design/spiram_in_if.sv -----
`timescale 1ns / 1ps

interface spiram_in_if
  import spiram_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/spiram_out_if.sv -----
`timescale 1ns / 1ps

interface spiram_out_if
  import spiram_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/spiram_cfg.sv -----
`timescale 1ns / 1ps

module spiram_cfg
  import spiram_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLOCK_MODE:  cfg_nxt.clock_mode  = cfg_data[0];
        CFG_PHASE_TICKS: cfg_nxt.phase_ticks = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_mode  <= 1'b1;
      cfg_r.phase_ticks <= PHASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/spiram_engine.sv -----
`timescale 1ns / 1ps

module spiram_engine
  import spiram_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t res
);

  phase_t               phase_r, phase_nxt;
  action_t              act_r, act_nxt;
  logic [7:0]           tx_r, tx_nxt;
  logic [7:0]           rx_r, rx_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [7:0]           wbyte_r, wbyte_nxt;
  logic                 cs_r, cs_nxt;
  logic                 sck_r, sck_nxt;
  logic                 mosi_r, mosi_nxt;

  logic [7:0]           plen;
  logic [7:0]           cnt_inc;
  logic [7:0]           left_dec;
  logic                 half_done;
  logic                 last_bit;
  logic                 act_ok;
  logic                 zero_burst;

  assign plen       = (cfg.phase_ticks == BYTE_ZERO) ? 8'd1 : cfg.phase_ticks;
  assign cnt_inc    = cnt_r + 8'd1;
  assign half_done  = (cnt_inc >= plen);
  assign last_bit   = (bit_idx_r == BIT_IDX_W'(BITS_PER_WORD - 1));
  assign left_dec   = left_r - 8'd1;
  assign zero_burst = (action_t'(item.action) == ACT_BURST) && (item.burst_length == BYTE_ZERO);
  assign act_ok     = (item.action <= ACT_BURST);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_ADDR_LO, PH_DATA_LO: begin
        if (half_done) phase_nxt = phase_t'(phase_r + 3'd1);
      end
      PH_ADDR_HI, PH_DATA_HI: begin
        if (half_done) begin
          if (!last_bit) begin
            phase_nxt = phase_t'(phase_r - 3'd1);
          end else if (phase_r == PH_ADDR_HI) begin
            phase_nxt = PH_DATA_LO;
          end else if (left_dec == BYTE_ZERO) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_DATA_LO;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item.start_req && !zero_burst && act_ok) phase_nxt = PH_ADDR_LO;
      end
    endcase
  end

  // datapath and lines
  always_comb begin
    act_nxt     = act_r;
    tx_nxt      = tx_r;
    rx_nxt      = rx_r;
    bit_idx_nxt = bit_idx_r;
    cnt_nxt     = cnt_r;
    left_nxt    = left_r;
    wbyte_nxt   = wbyte_r;
    cs_nxt      = cs_r;
    sck_nxt     = sck_r;
    mosi_nxt    = mosi_r;
    res         = '0;
    unique case (phase_r)
      PH_ADDR_LO, PH_DATA_LO: begin
        cnt_nxt = cnt_inc;
        if (half_done) begin
          cnt_nxt = 8'd0;
          rx_nxt  = {rx_r[6:0], item.miso};
          sck_nxt = 1'b1;
        end
      end
      PH_ADDR_HI, PH_DATA_HI: begin
        cnt_nxt = cnt_inc;
        if (half_done) begin
          cnt_nxt = 8'd0;
          if (!last_bit) begin
            bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            tx_nxt      = {tx_r[6:0], 1'b0};
            mosi_nxt    = tx_r[6];
            sck_nxt     = 1'b0;
          end else begin
            bit_idx_nxt = '0;
            if (phase_r == PH_ADDR_HI) begin
              tx_nxt   = (act_r == ACT_WRITE) ? wbyte_r : BYTE_ZERO;
              mosi_nxt = (act_r == ACT_WRITE) ? wbyte_r[7] : 1'b0;
              sck_nxt  = 1'b0;
            end else begin
              left_nxt = left_dec;
              if (act_r == ACT_WRITE) begin
                res.write_done = 1'b1;
              end else begin
                res.byte_valid   = 1'b1;
                res.read_byte    = rx_r;
                res.last_byte    = (left_dec == BYTE_ZERO);
                res.read_invalid = (act_r == ACT_READ) &&
                                   (rx_r == BYTE_ZERO || rx_r == BYTE_ALL_ONE);
              end
              if (left_dec == BYTE_ZERO) begin
                cs_nxt   = 1'b1;
                sck_nxt  = cfg.clock_mode;
                mosi_nxt = 1'b0;
              end else begin
                tx_nxt   = BYTE_ZERO;
                mosi_nxt = 1'b0;
                sck_nxt  = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        cs_nxt   = 1'b1;
        sck_nxt  = cfg.clock_mode;
        mosi_nxt = 1'b0;
        if (item.start_req) begin
          if (zero_burst) begin
            res.rejected = 1'b1;
          end else if (act_ok) begin
            act_nxt     = action_t'(item.action);
            wbyte_nxt   = item.write_data;
            tx_nxt      = (action_t'(item.action) == ACT_WRITE) ?
                          {1'b0, item.reg_addr & ADDR_MASK} : ({1'b0, item.reg_addr} | READ_FLAG);
            left_nxt    = (action_t'(item.action) == ACT_BURST) ? item.burst_length : 8'd1;
            rx_nxt      = BYTE_ZERO;
            bit_idx_nxt = '0;
            cnt_nxt     = 8'd0;
            cs_nxt      = 1'b0;
            mosi_nxt    = (action_t'(item.action) != ACT_WRITE);
            sck_nxt     = 1'b0;
          end
        end
      end
    endcase
    res.cs_n     = cs_nxt;
    res.sck      = sck_nxt;
    res.mosi     = mosi_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      act_r     <= ACT_READ;
      tx_r      <= '0;
      rx_r      <= '0;
      bit_idx_r <= '0;
      cnt_r     <= '0;
      left_r    <= '0;
      wbyte_r   <= '0;
      cs_r      <= 1'b1;
      sck_r     <= 1'b1;
      mosi_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      act_r     <= act_nxt;
      tx_r      <= tx_nxt;
      rx_r      <= rx_nxt;
      bit_idx_r <= bit_idx_nxt;
      cnt_r     <= cnt_nxt;
      left_r    <= left_nxt;
      wbyte_r   <= wbyte_nxt;
      cs_r      <= cs_nxt;
      sck_r     <= sck_nxt;
      mosi_r    <= mosi_nxt;
    end
  end

  a_cs_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cs_r == (phase_r == PH_IDLE))
    else $error("chip select out of step with sequencer");

  a_idle_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_idx_r == '0))
    else $error("bit index left nonzero after transaction");

  a_reject_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.rejected) |=> (phase_r == PH_IDLE))
    else $error("rejected burst started a transaction");

  a_byte_not_write: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.byte_valid) |-> (act_r != ACT_WRITE && phase_r == PH_DATA_HI))
    else $error("received byte outside a read data phase");

endmodule

// ----- design/spi_register_access_master.sv -----
`timescale 1ns / 1ps
// A result is registered in the output register when its tick is accepted.
// Throughput: one tick per cycle unless out_ch.ready stalls a held result;
// the single output register is refilled in the same cycle it is drained.
// Reset (rst_n low, synchronous): sequencer idle, cs_n high, sck high, mosi low,
// clock_mode = 1, phase_ticks = 10, no result pending.

module spi_register_access_master
  import spiram_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spiram_in_if.sink             in_ch,
  spiram_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  out_item_t res;
  logic      step;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  spiram_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spiram_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (in_ch.data),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !step)
    else $error("input taken while result register full");

  a_drain_without_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && !in_ch.valid) |=> !out_valid_r)
    else $error("result delivered twice");

endmodule
